[hw/rtl/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU cache table
// Entry record kept in the entry RAM, request codes and fixed result values.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

	typedef struct packed {
		logic [31:0] count;
		logic [31:0] value;
		logic [31:0] key;
	} entry_t;

	localparam logic        FUNC_GET   = 1'b0;
	localparam logic        FUNC_PUT   = 1'b1;
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
	localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
	localparam logic [31:0] COUNT_ONE  = 32'd1;
	localparam logic [4:0]  CAP_RESET  = 5'd16;

endpackage

`default_nettype wire

[hw/rtl/lfu_entry_ram.sv]
// ----------------------------------------------------------------------------
// lfu_entry_ram: entry storage of the LFU cache table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_entry_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  lfu_pkg::entry_t wdata,
	input  logic [AW-1:0]  raddr,
	output lfu_pkg::entry_t rdata
);
	import lfu_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/lfu_cache_table.sv]
// ----------------------------------------------------------------------------
// lfu_cache_table: fully associative key/value cache, LFU replacement
// Requests (get/put of a 32-bit key) enter on the s_ stream, one result beat
// per request leaves on the m_ stream.
//
// s_tdata: key [31:0], value [63:32]; s_tuser[0]: func (0 get, 1 put).
// m_tdata: read_value [31:0], evicted_key [63:32]; m_tuser: hit [0], evicted [1].
// cfg_wen/cfg_wdata write the capacity register (0 disables the cache);
// write it only while no request is in flight.
//
// Each request is handled alone: one pass over all MAX_ENTRIES entries of
// the entry RAM (one read per cycle through a single compare unit) finds the
// hit, the first free slot and the eviction victim, then the write-back
// state updates the RAM, the valid bits and the recency ranks. s_tready is
// high only between requests, so no new request is taken before the last
// one has been written back.
// The result sits in an output register; when the receiver stalls, the
// write-back waits until that register is free. Reset empties the cache and
// sets capacity to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key, value
	input  logic [0:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // read_value, evicted_key
	output logic [1:0]  m_tuser,   // hit, evicted
	input  logic        cfg_wen,
	input  logic [4:0]  cfg_wdata
);
	import lfu_pkg::*;

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CW     = (OCC_W > 5) ? OCC_W : 5;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
	localparam logic [CW-1:0]    MAX_CAP  = CW'(MAX_ENTRIES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WB   = 2'd2;

	logic [1:0]       state_q;
	logic [4:0]       cap_q;
	logic [OCC_W-1:0] occ_q;
	logic             func_q;
	logic [31:0]      key_q;
	logic [31:0]      val_q;

	logic             issue_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t           rd_s1;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [31:0]       hit_val_q;
	logic [31:0]       hit_cnt_q;
	logic [RANK_W-1:0] hit_rank_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              vic_q;
	logic [IDX_W-1:0]  vic_idx_q;
	logic [31:0]       vic_cnt_q;
	logic [RANK_W-1:0] vic_rank_q;
	logic [31:0]       vic_key_q;

	logic              valid_q [MAX_ENTRIES];
	logic [RANK_W-1:0] rank_q  [MAX_ENTRIES];

	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	// compare unit
	logic              e_valid;
	logic [RANK_W-1:0] e_rank;
	logic              key_match;
	logic              vic_better;

	// write-back decision
	logic              go;
	logic              wb_fire;
	logic [CW-1:0]     cap_ext;
	logic [CW-1:0]     cap_eff;
	logic [CW-1:0]     occ_ext;
	logic [OCC_W-1:0]  occ_m1;
	logic              sat;
	logic              o_hit;
	logic [31:0]       o_rd;
	logic              o_ev;
	logic [31:0]       o_evk;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;
	logic              do_newest;
	logic              do_insert;
	logic [IDX_W-1:0]  t_idx;
	logic [RANK_W-1:0] t_rank;

	lfu_entry_ram #(
		.DEPTH (MAX_ENTRIES),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (wb_fire && mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_idx_q),
		.rdata (rd_s1)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign e_valid    = valid_q[idx_s1];
	assign e_rank     = rank_q[idx_s1];
	assign key_match  = e_valid && (rd_s1.key == key_q);
	assign vic_better = e_valid && (!vic_q || (rd_s1.count < vic_cnt_q) ||
		((rd_s1.count == vic_cnt_q) && (e_rank < vic_rank_q)));

	assign cap_ext = CW'(cap_q);
	assign cap_eff = (cap_ext > MAX_CAP) ? MAX_CAP : cap_ext;
	assign occ_ext = CW'(occ_q);
	assign occ_m1  = occ_q - OCC_W'(1);
	assign sat     = (hit_cnt_q == COUNT_MAX);
	assign go      = !m_tvalid_q || m_tready;
	assign wb_fire = (state_q == ST_WB) && go;

	always_comb begin
		o_hit     = 1'b0;
		o_rd      = '0;
		o_ev      = 1'b0;
		o_evk     = '0;
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		mem_wdata = '{count: COUNT_ONE, value: val_q, key: key_q};
		do_newest = 1'b0;
		do_insert = 1'b0;
		t_idx     = hit_idx_q;
		t_rank    = hit_rank_q;
		if (cap_eff == '0) begin
			if (func_q == FUNC_GET) begin
				o_rd = MISS_VALUE;
			end
		end else if (hit_q) begin
			o_hit           = 1'b1;
			mem_we          = 1'b1;
			mem_wdata.count = sat ? hit_cnt_q : hit_cnt_q + 32'd1;
			do_newest       = !sat;
			if (func_q == FUNC_GET) begin
				o_rd            = hit_val_q;
				mem_wdata.value = hit_val_q;
			end
		end else if (func_q == FUNC_GET) begin
			o_rd = MISS_VALUE;
		end else if (occ_ext < cap_eff) begin
			mem_we    = 1'b1;
			mem_waddr = free_idx_q;
			do_insert = 1'b1;
		end else if (vic_q) begin
			o_ev      = 1'b1;
			o_evk     = vic_key_q;
			mem_we    = 1'b1;
			mem_waddr = vic_idx_q;
			do_newest = 1'b1;
			t_idx     = vic_idx_q;
			t_rank    = vic_rank_q;
		end
	end

	// sequencer and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cap_q      <= CAP_RESET;
			occ_q      <= '0;
			issue_q    <= 1'b0;
			rd_idx_q   <= '0;
			vld_s1     <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			vic_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cap_q <= cfg_wdata;
			end
			if (wb_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			vld_s1 <= (state_q == ST_SCAN) && issue_q;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q  <= ST_SCAN;
						issue_q  <= 1'b1;
						rd_idx_q <= '0;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						vic_q    <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (rd_idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + IDX_W'(1);
						end
					end
					if (vld_s1) begin
						if (!hit_q && key_match) begin
							hit_q <= 1'b1;
						end
						if (!free_q && !e_valid) begin
							free_q <= 1'b1;
						end
						if (vic_better) begin
							vic_q <= 1'b1;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= ST_WB;
						end
					end
				end
				ST_WB: begin
					if (go) begin
						state_q <= ST_IDLE;
						if (do_insert) begin
							occ_q <= occ_q + OCC_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (s_tvalid && s_tready) begin
			func_q <= s_tuser[0];
			key_q  <= s_tdata[31:0];
			val_q  <= s_tdata[63:32];
		end
		if (state_q == ST_SCAN && vld_s1) begin
			if (!hit_q && key_match) begin
				hit_idx_q  <= idx_s1;
				hit_val_q  <= rd_s1.value;
				hit_cnt_q  <= rd_s1.count;
				hit_rank_q <= e_rank;
			end
			if (!free_q && !e_valid) begin
				free_idx_q <= idx_s1;
			end
			if (vic_better) begin
				vic_idx_q  <= idx_s1;
				vic_cnt_q  <= rd_s1.count;
				vic_rank_q <= e_rank;
				vic_key_q  <= rd_s1.key;
			end
		end
		if (wb_fire) begin
			m_tdata_q <= {o_evk, o_rd};
			m_tuser_q <= {o_ev, o_hit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				valid_q[j] <= 1'b0;
			end
		end else if (wb_fire && do_insert) begin
			valid_q[free_idx_q] <= 1'b1;
		end
	end

	// recency ranks, one lane per entry
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if (wb_fire) begin
				if (do_insert && (free_idx_q == IDX_W'(j))) begin
					rank_q[j] <= occ_q[RANK_W-1:0];
				end else if (do_newest) begin
					if (t_idx == IDX_W'(j)) begin
						rank_q[j] <= occ_m1[RANK_W-1:0];
					end else if (valid_q[j] && (rank_q[j] > t_rank)) begin
						rank_q[j] <= rank_q[j] - RANK_W'(1);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lfu_checker.sv]
// ----------------------------------------------------------------------------
// lfu_checker: port-level checks for the LFU cache table
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// one request at a time: input closes right after a beat
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a request is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

	a_evict_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("eviction reported on a hit");

	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> (m_tdata[63:32] == 32'd0))
		else $error("evicted key nonzero without eviction");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
